>>> rtl/hba_pkg.sv
package hba_pkg;

  localparam int NUM_BINS    = 256;
  localparam int BIN_AW      = $clog2(NUM_BINS);
  localparam int SAMPLE_BITS = 16;
  localparam int COUNT_BITS  = 32;
  localparam int N_BITS      = BIN_AW + 1;
  localparam int CFG_AW      = 2;
  localparam int CFG_DW      = SAMPLE_BITS;
  localparam int MODE_W      = 2;

  // sample - range_low, range_high - range_low
  localparam int DIFF_W    = SAMPLE_BITS + 1;
  localparam int PROD_W    = DIFF_W + N_BITS + 1;
  localparam int NUM_W     = PROD_W + 1;
  // quotient bits kept before clamping; anything larger saturates
  localparam int QUOT_BITS = N_BITS;
  localparam int STEP_W    = $clog2(QUOT_BITS);

  localparam logic [COUNT_BITS-1:0] CNT_TOP = {COUNT_BITS{1'b1}};

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_READ  = 2'd1,
    MODE_CLEAR = 2'd2
  } mode_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_RANGE_LOW  = 2'd0,
    CFG_RANGE_HIGH = 2'd1,
    CFG_BINS       = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    BM_IDLE,
    BM_MUL,
    BM_NORM,
    BM_CHK,
    BM_DIV,
    BM_DONE
  } bm_state_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAP,
    ST_MOD
  } state_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] range_low;
    logic signed [SAMPLE_BITS-1:0] range_high;
    logic        [N_BITS-1:0]      n_bins;
  } cfg_t;

endpackage

>>> rtl/hba_if.sv
interface hba_in_if;
  logic                                    valid;
  logic                                    ready;
  logic        [hba_pkg::MODE_W-1:0]       mode;
  logic signed [hba_pkg::SAMPLE_BITS-1:0]  sample;
  logic        [hba_pkg::BIN_AW-1:0]       bin_select;

  modport source (output valid, mode, sample, bin_select, input ready);
  modport sink   (input valid, mode, sample, bin_select, output ready);
endinterface

interface hba_out_if;
  logic                              valid;
  logic                              ready;
  logic [hba_pkg::BIN_AW-1:0]        bin_index;
  logic [hba_pkg::COUNT_BITS-1:0]    bin_count;
  logic [hba_pkg::COUNT_BITS-1:0]    peak_count;

  modport source (output valid, bin_index, bin_count, peak_count, input ready);
  modport sink   (input valid, bin_index, bin_count, peak_count, output ready);
endinterface

interface hba_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [hba_pkg::CFG_AW-1:0]    index;
  logic [hba_pkg::CFG_DW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/hba_ram.sv
module hba_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/hba_binmap.sv
module hba_binmap (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   start,
  input  logic signed [hba_pkg::SAMPLE_BITS-1:0] sample,
  input  hba_pkg::cfg_t                          cfg,
  output logic                                   done,
  output logic        [hba_pkg::BIN_AW-1:0]      bin
);
  import hba_pkg::*;

  bm_state_t state_r, state_nxt;

  logic signed [DIFF_W-1:0]   diff_r;
  logic signed [DIFF_W-1:0]   den_r;
  logic        [DIFF_W-1:0]   dpos_r;
  logic signed [NUM_W-1:0]    num_r;
  logic        [NUM_W-1:0]    rem_r;
  logic        [NUM_W-1:0]    dsh_r;
  logic        [QUOT_BITS-1:0] q_r;
  logic        [STEP_W-1:0]   step_r;

  logic signed [N_BITS:0]     n_sgn;
  logic signed [PROD_W-1:0]   prod;
  logic        [NUM_W-1:0]    dlim;
  logic                       early;
  logic        [N_BITS-1:0]   n_m1;

  assign n_sgn = $signed({1'b0, cfg.n_bins});
  assign prod  = diff_r * n_sgn;
  assign dlim  = NUM_W'(dpos_r) << QUOT_BITS;
  assign early = (den_r == '0) || num_r[NUM_W-1] || ($unsigned(num_r) >= dlim);
  assign n_m1  = cfg.n_bins - N_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BM_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BM_IDLE: if (start) state_nxt = BM_MUL;
      BM_MUL:  state_nxt = BM_NORM;
      BM_NORM: state_nxt = BM_CHK;
      BM_CHK:  state_nxt = early ? BM_DONE : BM_DIV;
      BM_DIV:  if (step_r == '0) state_nxt = BM_DONE;
      BM_DONE: state_nxt = BM_IDLE;
      default: state_nxt = BM_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (state_r)
      BM_IDLE: begin
        if (start) begin
          diff_r <= DIFF_W'(sample) - DIFF_W'(cfg.range_low);
          den_r  <= DIFF_W'(cfg.range_high) - DIFF_W'(cfg.range_low);
        end
      end
      BM_MUL: begin
        num_r <= NUM_W'(prod);
      end
      BM_NORM: begin
        // flip both signs so the divisor is positive; floor is unchanged
        if (den_r[DIFF_W-1]) begin
          num_r  <= -num_r;
          dpos_r <= $unsigned(-den_r);
        end else begin
          dpos_r <= $unsigned(den_r);
        end
      end
      BM_CHK: begin
        q_r    <= (den_r != '0 && !num_r[NUM_W-1] && ($unsigned(num_r) >= dlim)) ? '1 : '0;
        rem_r  <= $unsigned(num_r);
        dsh_r  <= NUM_W'(dpos_r) << (QUOT_BITS - 1);
        step_r <= STEP_W'(QUOT_BITS - 1);
      end
      BM_DIV: begin
        if (rem_r >= dsh_r) begin
          rem_r       <= rem_r - dsh_r;
          q_r[step_r] <= 1'b1;
        end
        dsh_r  <= dsh_r >> 1;
        step_r <= step_r - STEP_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign done = (state_r == BM_DONE);
  assign bin  = (q_r > n_m1) ? n_m1[BIN_AW-1:0] : q_r[BIN_AW-1:0];

endmodule

>>> rtl/histogram_bin_accumulator_top.sv
// Add item, worst case: multiply, sign fix, range check, 9-step divider, count read, update;
// the divider is skipped for an empty range, a sample below it or a quotient past 511;
// read items only do the count read and update. A new item is taken only while idle.
// Rate set by the bit-serial divider and the count RAM read-modify-write; a result left
// waiting in the output register holds back the update of the next item.
// Sync active-low reset: config to defaults, peak zero, bins zero via per-bin valid flags.
module histogram_bin_accumulator_top (
  input logic     clk,
  input logic     rst_n,
  hba_in_if.sink  in_if,
  hba_out_if.source out_if,
  hba_cfg_if.sink cfg_if
);
  import hba_pkg::*;

  logic signed [SAMPLE_BITS-1:0] range_low_r, range_high_r;
  logic        [N_BITS-1:0]      bins_r;
  logic        [N_BITS-1:0]      n_eff;
  cfg_t                          cfg;

  state_t state_r, state_nxt;

  logic [MODE_W-1:0]     mode_r;
  logic [BIN_AW-1:0]     addr_r;
  logic [NUM_BINS-1:0]   vld_r;
  logic                  rvld_r;
  logic [COUNT_BITS-1:0] peak_r;

  logic                  out_valid_r;
  logic [BIN_AW-1:0]     out_idx_r;
  logic [COUNT_BITS-1:0] out_cnt_r;
  logic [COUNT_BITS-1:0] out_peak_r;

  logic                  in_acc, bm_start, bm_done, re, fire, out_free, is_add;
  logic [BIN_AW-1:0]     bm_bin, raddr;
  logic [COUNT_BITS-1:0] rdata, cur, inc, peak_nxt;

  // configuration
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      range_low_r  <= '0;
      range_high_r <= 16'sd32767;
      bins_r       <= N_BITS'(NUM_BINS);
    end else if (cfg_if.valid) begin
      unique case (cfg_if.index)
        CFG_RANGE_LOW:  range_low_r  <= $signed(cfg_if.data);
        CFG_RANGE_HIGH: range_high_r <= $signed(cfg_if.data);
        CFG_BINS:       bins_r       <= cfg_if.data[N_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (bins_r == '0) begin
      n_eff = N_BITS'(1);
    end else if (bins_r > N_BITS'(NUM_BINS)) begin
      n_eff = N_BITS'(NUM_BINS);
    end else begin
      n_eff = bins_r;
    end
  end

  assign cfg.range_low  = range_low_r;
  assign cfg.range_high = range_high_r;
  assign cfg.n_bins     = n_eff;

  hba_binmap u_binmap (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (bm_start),
    .sample (in_if.sample),
    .cfg    (cfg),
    .done   (bm_done),
    .bin    (bm_bin)
  );

  // control
  assign in_if.ready = (state_r == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign is_add      = (mode_r == MODE_ADD);
  assign raddr       = (state_r == ST_IDLE) ? in_if.bin_select : bm_bin;

  assign cur      = rvld_r ? rdata : '0;
  assign inc      = (cur == CNT_TOP) ? cur : cur + COUNT_BITS'(1);
  assign peak_nxt = (is_add && inc > peak_r) ? inc : peak_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    bm_start  = 1'b0;
    re        = 1'b0;
    fire      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_if.mode == MODE_ADD) begin
            bm_start  = 1'b1;
            state_nxt = ST_MAP;
          end else begin
            re        = 1'b1;
            state_nxt = ST_MOD;
          end
        end
      end
      ST_MAP: begin
        if (bm_done) begin
          re        = 1'b1;
          state_nxt = ST_MOD;
        end
      end
      ST_MOD: begin
        if (out_free) begin
          fire      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      mode_r <= in_if.mode;
    end
    if (re) begin
      addr_r <= raddr;
      rvld_r <= vld_r[raddr];
    end
  end

  // count store; an entry without its valid flag reads as zero
  hba_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_ram (
    .clk   (clk),
    .we    (fire && is_add),
    .waddr (addr_r),
    .wdata (inc),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r  <= '0;
      peak_r <= '0;
    end else if (fire) begin
      peak_r <= peak_nxt;
      if (is_add) begin
        vld_r[addr_r] <= 1'b1;
      end else if (mode_r == MODE_CLEAR) begin
        vld_r[addr_r] <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_idx_r  <= addr_r;
      out_cnt_r  <= is_add ? inc : cur;
      out_peak_r <= peak_nxt;
    end
  end

  assign out_if.valid      = out_valid_r;
  assign out_if.bin_index  = out_idx_r;
  assign out_if.bin_count  = out_cnt_r;
  assign out_if.peak_count = out_peak_r;

endmodule
